/* rtl/core/composite_glyph_index_remapper_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the composite glyph index remapper
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef COMPOSITE_GLYPH_INDEX_REMAPPER_TOP_ASSERT_SVH
`define COMPOSITE_GLYPH_INDEX_REMAPPER_TOP_ASSERT_SVH

// Same-cycle implication.
`define CGIR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cgir: assertion failed");

// Next-cycle implication.
`define CGIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cgir: assertion failed");

`endif

/* rtl/core/cgir_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cgir_pkg
// Shared types and constants of the composite glyph index remapper.
// ---------------------------------------------------------------------------
package cgir_pkg;

  localparam int unsigned TableDepthDef = 256;
  localparam int unsigned WordW         = 16;
  localparam int unsigned SubCntW       = 9;
  localparam int unsigned TdataW        = 32;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DATA = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    GS_OPEN  = 2'd0,
    GS_DONE  = 2'd1,
    GS_SHORT = 2'd2
  } gstat_e;

  // Result item, word_out in the low bits.
  typedef struct packed {
    logic [SubCntW-1:0] subset_count;
    logic               table_full;
    gstat_e             glyph_status;
    logic               index_rewritten;
    logic [WordW-1:0]   word_out;
  } res_t;

  localparam int unsigned ResW = $bits(res_t);

  // Parser -> sequencer.
  typedef struct packed {
    logic   index_req;
    gstat_e status;
  } parse_info_t;

  // Table unit -> sequencer.
  typedef struct packed {
    logic             done;
    logic             ok;
    logic [WordW-1:0] word;
  } tbl_res_t;

endpackage

/* rtl/core/cgir_parser.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cgir_parser
// Glyph word parser: header, component flags, index and argument words.
// ---------------------------------------------------------------------------
module cgir_parser import cgir_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WordW-1:0] word_i,
  input  logic             last_i,
  output parse_info_t      info_o
);

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_PASS   = 5'b00010,
    PH_FLAGS  = 5'b00100,
    PH_INDEX  = 5'b01000,
    PH_ARGS   = 5'b10000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [2:0] wpos_q, wpos_d;
  logic [2:0] args_q, args_d;
  logic [2:0] args_dec;
  logic [2:0] nargs;
  logic [2:0] scale_words;
  logic       more_q, more_d;
  logic       neg_q, neg_d;

  // argument words of a component: offsets, then the scale form
  always_comb begin
    if (word_i[3]) begin
      scale_words = 3'd1;
    end else if (word_i[6]) begin
      scale_words = 3'd2;
    end else if (word_i[7]) begin
      scale_words = 3'd4;
    end else begin
      scale_words = 3'd0;
    end
    nargs = 3'd1 + {2'b00, word_i[0]} + scale_words;
  end

  always_comb begin
    phase_d = phase_q;
    wpos_d  = wpos_q;
    args_d  = args_q;
    more_d  = more_q;
    neg_d   = neg_q;
    args_dec = (args_q != 3'd0) ? (args_q - 3'd1) : args_q;
    info_o.index_req = 1'b0;
    info_o.status    = GS_OPEN;
    case (phase_q)
      PH_HEADER: begin
        if (wpos_q == 3'd0) begin
          neg_d = word_i[15];
        end
        if (last_i) begin
          info_o.status = GS_SHORT;
        end else if (wpos_q >= 3'd4) begin
          phase_d = neg_d ? PH_FLAGS : PH_PASS;
          neg_d   = 1'b0;
          wpos_d  = 3'd0;
        end else begin
          wpos_d = wpos_q + 3'd1;
        end
      end
      PH_FLAGS: begin
        more_d = word_i[5];
        args_d = nargs;
        if (last_i) begin
          info_o.status = GS_SHORT;
        end else begin
          phase_d = PH_INDEX;
        end
      end
      PH_INDEX: begin
        if (last_i) begin
          info_o.status = GS_SHORT;
        end else begin
          info_o.index_req = 1'b1;
          phase_d = PH_ARGS;
        end
      end
      PH_ARGS: begin
        if (last_i) begin
          info_o.status = more_q ? GS_SHORT : GS_DONE;
        end else begin
          args_d = args_dec;
          if (args_dec == 3'd0) begin
            phase_d = more_q ? PH_FLAGS : PH_PASS;
          end
        end
      end
      PH_PASS: begin
        if (last_i) begin
          info_o.status = GS_DONE;
        end
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase
    // a final word always restarts the parser
    if (last_i) begin
      phase_d = PH_HEADER;
      wpos_d  = 3'd0;
      args_d  = 3'd0;
      more_d  = 1'b0;
      neg_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      wpos_q  <= 3'd0;
      args_q  <= 3'd0;
      more_q  <= 1'b0;
      neg_q   <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      wpos_q  <= wpos_d;
      args_q  <= args_d;
      more_q  <= more_d;
      neg_q   <= neg_d;
    end
  end

endmodule

/* rtl/core/cgir_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cgir_table
// Subset table memory with one shared compare unit that scans it entry by
// entry, and the fill count that marks the written entries.
// ---------------------------------------------------------------------------
`include "composite_glyph_index_remapper_top_assert.svh"

module cgir_table import cgir_pkg::*; #(
  parameter  int unsigned Depth = TableDepthDef,
  localparam int unsigned AddrW = $clog2(Depth),
  localparam int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             app_i,
  input  logic [WordW-1:0] app_id_i,
  input  logic             start_i,
  input  logic [WordW-1:0] key_i,
  output logic [CntW-1:0]  cnt_o,
  output logic [CntW-1:0]  cnt_nxt_o,
  output logic             full_o,
  output tbl_res_t         res_o
);

  logic [WordW-1:0] mem_q [Depth];
  logic [WordW-1:0] rd_data_q;
  logic [WordW-1:0] key_q;
  logic [WordW-1:0] wr_data;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  rd_idx_q;
  logic [AddrW-1:0] cmp_idx_q;
  logic             cmp_vld_q;
  logic             busy_q;
  logic             full;
  logic             issue;
  logic             hit;
  logic             miss;
  logic             wr_en;

  assign full  = (cnt_q == CntW'(Depth));
  assign issue = busy_q && (rd_idx_q < cnt_q);
  // first match wins: the scan stops at the lowest matching entry
  assign hit   = busy_q && cmp_vld_q && (rd_data_q == key_q);
  assign miss  = busy_q && !cmp_vld_q && !issue;

  assign wr_en   = (app_i || miss) && !full;
  assign wr_data = app_i ? app_id_i : key_q;
  assign cnt_d   = cnt_q + CntW'(wr_en);

  always_comb begin
    res_o.done = hit || miss;
    res_o.ok   = hit || (miss && !full);
    if (hit) begin
      res_o.word = WordW'(cmp_idx_q);
    end else if (!full) begin
      res_o.word = WordW'(cnt_q);
    end else begin
      res_o.word = key_q;
    end
  end

  assign cnt_o     = cnt_q;
  assign cnt_nxt_o = cnt_d;
  assign full_o    = full;

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[AddrW-1:0]] <= wr_data;
    end
    rd_data_q <= mem_q[rd_idx_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      busy_q    <= 1'b0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (start_i) begin
        busy_q    <= 1'b1;
        rd_idx_q  <= '0;
        cmp_vld_q <= 1'b0;
      end else if (busy_q) begin
        busy_q    <= !(hit || miss);
        cmp_vld_q <= issue;
        if (issue) begin
          rd_idx_q <= rd_idx_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    if (issue) begin
      cmp_idx_q <= rd_idx_q[AddrW-1:0];
    end
  end

  `CGIR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CntW'(Depth))
  `CGIR_ASSERT_NOW(a_miss_only_full, res_o.done && !res_o.ok, full)
  `CGIR_ASSERT_NOW(a_no_overlap, busy_q, !app_i && !start_i)
  `CGIR_ASSERT_NEXT(a_app_grow, app_i && !full, cnt_q == $past(cnt_q) + CntW'(1))

endmodule

/* rtl/core/cgir_outbuf.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cgir_outbuf
// Two-entry output register with skid stage on the result stream.
// ---------------------------------------------------------------------------
module cgir_outbuf import cgir_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [TdataW-1:0] data_i,
  output logic              ready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [TdataW-1:0] m_tdata_o
);

  logic              out_vld_q;
  logic              skid_vld_q;
  logic [TdataW-1:0] out_q;
  logic [TdataW-1:0] skid_q;
  logic              take;

  assign take       = out_vld_q && m_tready_i;
  assign ready_o    = !skid_vld_q;
  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (push_i) begin
      if (out_vld_q && !take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (take) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (out_vld_q && !take) begin
        skid_q <= data_i;
      end else begin
        out_q <= data_i;
      end
    end else if (take && skid_vld_q) begin
      out_q <= skid_q;
    end
  end

endmodule

/* rtl/core/composite_glyph_index_remapper_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// composite_glyph_index_remapper_top
// Rewrites TrueType composite glyph component indices to subset positions.
// ---------------------------------------------------------------------------
// Load items (tuser = 0) append an old glyph id to the subset table. Data
// items (tuser = 1) carry one glyph as big-endian 16-bit words, tlast on the
// final word. After the 5-word header, a glyph with a negative contour count
// is parsed as composite: each component index word is looked up in the
// table (lowest matching entry wins) or appended, and replaced by its table
// position. Every item returns exactly one result item. Load items and all
// non-index words are pushed to the output buffer in the cycle they are
// accepted. A component index word scans the table one entry per cycle
// through the single memory read port and comparator over the N entries
// held, stopping early when it matches. No item is accepted while
// a scan is running; a finished result may wait in the two-entry output
// buffer while the next item comes in. The table holds no reset value:
// only the entry count clears, and entries at or beyond it are never read.
// ---------------------------------------------------------------------------
module composite_glyph_index_remapper_top import cgir_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,  // [15:0] data_word
  input  logic              s_axis_tlast,  // last_word
  input  logic              s_axis_tuser,  // operation
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata   // [15:0] word_out, [16] index_rewritten,
                                           // [18:17] glyph_status, [19] table_full,
                                           // [28:20] subset_count, [31:29] zero
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  // sequencer
  typedef enum logic [2:0] {
    SQ_IDLE = 3'b001,
    SQ_SCAN = 3'b010,
    SQ_DONE = 3'b100
  } seq_e;

  seq_e seq_q, seq_d;

  logic              acc;
  logic              is_data;
  logic              app;
  logic              pen;
  logic              start;
  logic              buf_rdy;
  logic              push;
  res_t              push_res;
  res_t              hold_q;
  parse_info_t       pinfo;
  tbl_res_t          tres;
  logic              tbl_full;
  logic [CntW-1:0]   cnt, cnt_nxt;
  logic [CntW+8:0]   cnt_ext, cnt_nxt_ext;
  logic [SubCntW-1:0] sub_now, sub_nxt;

  assign s_axis_tready = (seq_q == SQ_IDLE) && buf_rdy;
  assign acc     = s_axis_tvalid && s_axis_tready;
  assign is_data = (op_e'(s_axis_tuser) == OP_DATA);
  assign app     = acc && !is_data;
  assign pen     = acc && is_data;
  assign start   = pen && pinfo.index_req;

  // subset_count reports the low 9 bits of the entry count
  assign cnt_ext     = (CntW + 9)'(cnt);
  assign cnt_nxt_ext = (CntW + 9)'(cnt_nxt);
  assign sub_now     = cnt_ext[SubCntW-1:0];
  assign sub_nxt     = cnt_nxt_ext[SubCntW-1:0];

  cgir_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pen),
    .word_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .info_o (pinfo)
  );

  cgir_table #(
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .app_i     (app),
    .app_id_i  (s_axis_tdata),
    .start_i   (start),
    .key_i     (s_axis_tdata),
    .cnt_o     (cnt),
    .cnt_nxt_o (cnt_nxt),
    .full_o    (tbl_full),
    .res_o     (tres)
  );

  // result selection: items that start no scan push at accept, scans via hold_q
  always_comb begin
    push     = 1'b0;
    push_res = '0;
    if (seq_q == SQ_DONE) begin
      push     = buf_rdy;
      push_res = hold_q;
    end else if (acc && !start) begin
      push = 1'b1;
      if (is_data) begin
        push_res.word_out     = s_axis_tdata;
        push_res.glyph_status = pinfo.status;
        push_res.subset_count = sub_now;
      end else begin
        push_res.table_full   = tbl_full;
        push_res.subset_count = sub_nxt;
      end
    end
  end

  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SQ_IDLE: begin
        if (start) begin
          seq_d = SQ_SCAN;
        end
      end
      SQ_SCAN: begin
        if (tres.done) begin
          seq_d = SQ_DONE;
        end
      end
      SQ_DONE: begin
        if (buf_rdy) begin
          seq_d = SQ_IDLE;
        end
      end
      default: begin
        seq_d = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SQ_IDLE;
    end else begin
      seq_q <= seq_d;
    end
  end

  // scan outcome held until the output buffer has room
  always_ff @(posedge clk_i) begin
    if ((seq_q == SQ_SCAN) && tres.done) begin
      hold_q.word_out        <= tres.word;
      hold_q.index_rewritten <= tres.ok;
      hold_q.glyph_status    <= GS_OPEN;
      hold_q.table_full      <= !tres.ok;
      hold_q.subset_count    <= sub_nxt;
    end
  end

  cgir_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     ({(TdataW - ResW)'(0), push_res}),
    .ready_o    (buf_rdy),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

/* test/tb_composite_glyph_index_remapper_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_composite_glyph_index_remapper_top
// Self-checking testbench for the composite glyph index remapper.
// ---------------------------------------------------------------------------
// Drives load and glyph-word items into the slave stream and checks every
// result item on the master stream against a cycle-free model of the
// subset table and the composite glyph parser. A short directed part comes
// first, then random glyph traffic under four idle/stall mixes, and last a
// run that fills the subset table and hits the table-full paths.
// ---------------------------------------------------------------------------
module tb_composite_glyph_index_remapper_top;
  import cgir_pkg::*;

  localparam int unsigned TABLE_DEPTH = TableDepthDef;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned DRAIN_CYCLES = 300;   // > longest scan of a full table
  localparam int unsigned GROWTH_CAP = 200;     // keep random appends below this

  // Component flag bits and the composite marker in the contour count word.
  localparam logic [15:0] FL_ARGS_WORDS = 16'h0001;
  localparam logic [15:0] FL_SCALE      = 16'h0008;
  localparam logic [15:0] FL_MORE       = 16'h0020;
  localparam logic [15:0] FL_XY_SCALE   = 16'h0040;
  localparam logic [15:0] FL_TWO_BY_TWO = 16'h0080;
  localparam logic [15:0] CONTOUR_SIGN  = 16'h8000;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PASS,
    PH_FLAGS,
    PH_INDEX,
    PH_ARGS
  } parse_ph_e;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;   // [15:0] data_word
  logic              s_axis_tlast;   // last_word
  logic              s_axis_tuser;   // operation
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [TdataW-1:0] m_axis_tdata;   // [15:0] word_out, [16] index_rewritten,
                                     // [18:17] glyph_status, [19] table_full,
                                     // [28:20] subset_count

  composite_glyph_index_remapper_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Model state: subset table and glyph parser.
  logic [15:0] subset_ids [TABLE_DEPTH];
  int unsigned subset_len;
  parse_ph_e   parse_ph;
  int unsigned word_pos;
  int unsigned args_left;
  logic        more_comp;
  logic [15:0] comp_flags;

  res_t        expected_remaps [$];
  logic [15:0] glyph_words [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          inject_loads;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned loads_sent;
  int unsigned glyphs_sent;
  int unsigned results_checked;
  int unsigned full_refusals;

  function automatic void restart_parser();
    parse_ph   = PH_HEADER;
    word_pos   = 0;
    args_left  = 0;
    more_comp  = 1'b0;
    comp_flags = '0;
  endfunction

  // Works out the result of one accepted item and advances the model.
  function automatic res_t predict_remap(op_e op, logic [15:0] w, logic l);
    res_t        r;
    int unsigned n;
    int unsigned pos;
    bit          found;
    r = '0;
    r.glyph_status = GS_OPEN;
    if (op == OP_LOAD) begin
      if (subset_len >= TABLE_DEPTH) begin
        r.table_full = 1'b1;
      end else begin
        subset_ids[subset_len] = w;
        subset_len++;
      end
    end else begin
      r.word_out = w;
      case (parse_ph)
        PH_HEADER: begin
          if (word_pos == 0) comp_flags = w;
          if (l) begin
            r.glyph_status = GS_SHORT;
          end else if (word_pos >= 4) begin
            parse_ph   = (comp_flags & CONTOUR_SIGN) != 0 ? PH_FLAGS : PH_PASS;
            comp_flags = '0;
            word_pos   = 0;
          end else begin
            word_pos++;
          end
        end
        PH_FLAGS: begin
          n = 1;
          comp_flags = w;
          more_comp  = (w & FL_MORE) != 0;
          if ((w & FL_ARGS_WORDS) != 0) n++;
          if ((w & FL_SCALE) != 0) n += 1;
          else if ((w & FL_XY_SCALE) != 0) n += 2;
          else if ((w & FL_TWO_BY_TWO) != 0) n += 4;
          args_left = n;
          if (l) r.glyph_status = GS_SHORT;
          else parse_ph = PH_INDEX;
        end
        PH_INDEX: begin
          if (l) begin
            r.glyph_status = GS_SHORT;
          end else begin
            // first match wins, entry 0 included; append when absent
            found = 1'b0;
            pos   = 0;
            for (int unsigned i = 0; i < subset_len; i++) begin
              if (!found && subset_ids[i] == w) begin
                found = 1'b1;
                pos   = i;
              end
            end
            if (!found && subset_len < TABLE_DEPTH) begin
              subset_ids[subset_len] = w;
              pos   = subset_len;
              found = 1'b1;
              subset_len++;
            end
            if (found) begin
              r.word_out        = pos[15:0];
              r.index_rewritten = 1'b1;
            end else begin
              r.table_full = 1'b1;
            end
            parse_ph = PH_ARGS;
          end
        end
        PH_ARGS: begin
          if (l) begin
            r.glyph_status = more_comp ? GS_SHORT : GS_DONE;
          end else begin
            if (args_left > 0) args_left--;
            if (args_left == 0) parse_ph = more_comp ? PH_FLAGS : PH_PASS;
          end
        end
        default: begin
          if (l) r.glyph_status = GS_DONE;
        end
      endcase
      if (l) restart_parser();
    end
    r.subset_count = subset_len[SubCntW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Sends one item; the caller is at a falling edge and returns at one.
  task automatic send_item(op_e op, logic [15:0] w, logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = 16'($urandom);
      s_axis_tlast  = 1'($urandom_range(1));
      s_axis_tuser  = 1'($urandom_range(1));
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = w;
    s_axis_tlast  = l;
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_remaps.push_back(predict_remap(op, w, l));
    items_sent++;
    if (op == OP_LOAD) loads_sent++;
    @(negedge clk_i);
  endtask

  // Sends glyph_words[0..cut], last on the word at cut; loads may slip in.
  task automatic send_glyph_words(int unsigned cut);
    for (int unsigned i = 0; i <= cut; i++) begin
      if (inject_loads && subset_len < GROWTH_CAP && $urandom_range(99) < 3)
        send_item(OP_LOAD, 16'($urandom), 1'($urandom_range(1)));
      send_item(OP_DATA, glyph_words[i], i == cut);
    end
    glyphs_sent++;
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid = 1'b0;
    while (expected_remaps.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_table_loads();
    send_item(OP_LOAD, 16'h0000, 1'b0);
    send_item(OP_LOAD, 16'hFFFF, 1'b1);
    send_item(OP_LOAD, 16'hFFFF, 1'b0);   // duplicate id is appended again
  endtask

  task automatic test_short_glyph();
    send_item(OP_DATA, CONTOUR_SIGN, 1'b1);   // ends inside the header
  endtask

  task automatic test_composite_glyph();
    // Two components: word args + more, then xy scale over 2x2 (xy wins).
    // The first index hits the duplicated id, the second hits entry 0.
    glyph_words = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8001,
                    FL_ARGS_WORDS | FL_MORE, 16'hFFFF, 16'h1234, 16'h5678,
                    FL_XY_SCALE | FL_TWO_BY_TWO, 16'h0000,
                    16'hAAAA, 16'h5555, 16'h0F0F, 16'hFFFF};
    send_glyph_words(glyph_words.size() - 1);
  endtask

  task automatic test_broken_composite();
    // Glyph cut off on its index word: no remap, no append.
    glyph_words = '{CONTOUR_SIGN, 16'h0001, 16'h0002, 16'h0003, 16'h0004,
                    FL_SCALE | FL_TWO_BY_TWO, 16'h4242};
    send_glyph_words(glyph_words.size() - 1);
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int unsigned n_comp;
    int unsigned n_args;
    int unsigned cut;
    bit          composite;
    logic [15:0] fl;
    logic [15:0] id;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        // well-formed glyph, cut at a random word 10 times in 85
        composite = $urandom_range(99) < 80;
        glyph_words.delete();
        glyph_words.push_back(composite ? (16'($urandom) | CONTOUR_SIGN)
                                        : (16'($urandom) & ~CONTOUR_SIGN));
        repeat (4) glyph_words.push_back(16'($urandom));
        if (composite) begin
          n_comp = $urandom_range(1, 3);
          for (int unsigned c = 0; c < n_comp; c++) begin
            fl = 16'($urandom);
            fl = (c + 1 < n_comp) ? (fl | FL_MORE) : (fl & ~FL_MORE);
            glyph_words.push_back(fl);
            if (subset_len > 0 && (subset_len >= GROWTH_CAP || $urandom_range(99) < 70))
              id = subset_ids[$urandom_range(0, subset_len - 1)];
            else
              id = 16'($urandom);
            glyph_words.push_back(id);
            n_args = 1;
            if ((fl & FL_ARGS_WORDS) != 0) n_args++;
            if ((fl & FL_SCALE) != 0) n_args += 1;
            else if ((fl & FL_XY_SCALE) != 0) n_args += 2;
            else if ((fl & FL_TWO_BY_TWO) != 0) n_args += 4;
            repeat (n_args) glyph_words.push_back(16'($urandom));
          end
          repeat ($urandom_range(0, 3)) glyph_words.push_back(16'($urandom));
        end else begin
          repeat ($urandom_range(1, 8)) glyph_words.push_back(16'($urandom));
        end
        if (pick < 10) cut = $urandom_range(0, glyph_words.size() - 1);
        else cut = glyph_words.size() - 1;
        send_glyph_words(cut);
      end else if (pick < 93) begin
        if (subset_len < GROWTH_CAP)
          send_item(OP_LOAD, 16'($urandom), 1'($urandom_range(1)));
      end else begin
        // noise burst, usually closed by a final word
        repeat ($urandom_range(1, 4))
          send_item(OP_DATA, 16'($urandom), 1'($urandom_range(99) < 15));
        if ($urandom_range(99) < 80) send_item(OP_DATA, 16'($urandom), 1'b1);
      end
    end
  endtask

  task automatic test_table_full();
    logic [15:0] absent_id;
    bit          clash;
    while (subset_len < TABLE_DEPTH)
      send_item(OP_LOAD, 16'($urandom), 1'($urandom_range(1)));
    send_item(OP_LOAD, 16'h0000, 1'b0);   // refused
    send_item(OP_LOAD, 16'hFFFF, 1'b1);   // refused
    do begin
      absent_id = 16'($urandom);
      clash = 1'b0;
      for (int unsigned i = 0; i < subset_len; i++)
        if (subset_ids[i] == absent_id) clash = 1'b1;
    end while (clash);
    // Index found deep in a full table, then one that cannot be stored.
    glyph_words = '{CONTOUR_SIGN | 16'h0002, 16'h0010, 16'h0020, 16'h0030, 16'h0040,
                    FL_MORE, subset_ids[TABLE_DEPTH-1], 16'h0102,
                    16'h0000, absent_id, 16'h0304};
    send_glyph_words(glyph_words.size() - 1);
  endtask

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[ResW-1:0]);
      if (expected_remaps.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata, '0);
      end else begin
        want = expected_remaps.pop_front();
        results_checked++;
        if (got.word_out !== want.word_out)
          report_mismatch("word_out", 32'(got.word_out), 32'(want.word_out));
        if (got.index_rewritten !== want.index_rewritten)
          report_mismatch("index_rewritten", 32'(got.index_rewritten),
                          32'(want.index_rewritten));
        if (got.glyph_status !== want.glyph_status)
          report_mismatch("glyph_status", 32'(got.glyph_status), 32'(want.glyph_status));
        if (got.table_full !== want.table_full)
          report_mismatch("table_full", 32'(got.table_full), 32'(want.table_full));
        if (got.subset_count !== want.subset_count)
          report_mismatch("subset_count", 32'(got.subset_count), 32'(want.subset_count));
        if (m_axis_tdata[TdataW-1:ResW] !== '0)
          report_mismatch("pad bits", 32'(m_axis_tdata[TdataW-1:ResW]), '0);
        if (want.table_full) full_refusals++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, expected_remaps.size());
      $display("composite_glyph_index_remapper_top verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    s_axis_tuser   = 1'b0;
    m_axis_tready  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    inject_loads   = 1'b0;
    cycle_count    = 0;
    error_count    = 0;
    items_sent     = 0;
    loads_sent     = 0;
    glyphs_sent    = 0;
    results_checked = 0;
    full_refusals  = 0;
    subset_len     = 0;
    restart_parser();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_table_loads();
    test_short_glyph();
    test_composite_glyph();
    test_broken_composite();

    inject_loads = 1'b1;
    // free flow, sender gaps, receiver stalls, both
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = (p == 1 || p == 3) ? ((p == 3) ? 21 : 60) : 0;
      recv_stall_pct = (p == 2 || p == 3) ? ((p == 3) ? 21 : 60) : 0;
      test_random_traffic(230);
      if (p == 1) hold_until_drained();   // sender waits out every result
    end

    test_table_full();

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items: %0d loads, %0d glyphs; %0d results checked.",
             items_sent, loads_sent, glyphs_sent, results_checked);
    $display("Subset table reached %0d entries, %0d refusals on a full table.",
             subset_len, full_refusals);
    if (error_count == 0 && expected_remaps.size() == 0) begin
      $display("composite_glyph_index_remapper_top verification clean");
    end else begin
      $display("composite_glyph_index_remapper_top verification failed");
    end
    $finish;
  end

endmodule
